// ===== rtl/srs_pkg.sv =====
// Shared constants, types and codes for the signed rank statistic block.
package srs_pkg;

   localparam int N_MAX       = 1024;
   localparam int IDX_W       = $clog2(N_MAX);
   localparam int CNT_W       = $clog2(N_MAX + 1);
   localparam int SCORE_W     = 32;
   localparam int LABEL_W     = 8;
   localparam int SUM_W       = SCORE_W + IDX_W;
   localparam int PROD_W      = SCORE_W + CNT_W + 1;
   localparam int DIFF_W      = PROD_W + 1;
   localparam int RANK_SUM_W  = 20;
   localparam int TCOUNT_W    = 11;
   localparam int ACC_W       = (2 * CNT_W > RANK_SUM_W) ? 2 * CNT_W : RANK_SUM_W;
   localparam int OUTC_W      = (CNT_W > TCOUNT_W) ? CNT_W : TCOUNT_W;
   localparam int MEM_W       = LABEL_W + SCORE_W;
   localparam int DIR_W       = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_LABEL = 1'b1;

   localparam logic signed [DIR_W-1:0] DIR_ABOVE = 2'sb01;
   localparam logic signed [DIR_W-1:0] DIR_BELOW = 2'sb11;

   typedef struct packed {
      logic               last;
      logic [IDX_W-1:0]   index;
      logic [LABEL_W-1:0] label;
   } key_tag_type;

   typedef struct packed {
      logic        valid;
      key_tag_type tag;
   } key_req_type;

   typedef struct packed {
      logic              valid;
      key_tag_type       tag;
      logic [DIFF_W-1:0] key;
      logic              pos;
      logic              neg;
   } key_rsp_type;

endpackage

// ===== rtl/srs_ram.sv =====
// Simple dual-port RAM with registered read data.
module srs_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/srs_key_unit.sv =====
// Pipelined key unit: |C*local - S| with sign flags, three register stages.
module srs_key_unit
   import srs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  key_req_type               req,
   input  logic signed [SCORE_W-1:0] score,
   input  logic [CNT_W-1:0]          count,
   input  logic signed [SUM_W-1:0]   sum,
   output key_rsp_type               rsp
);

   logic                      v1_ff, v2_ff, v3_ff;
   key_tag_type               tag1_ff, tag2_ff, tag3_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic [DIFF_W-1:0]         key_ff, key_in;
   logic                      pos_ff, neg_ff;

   always_comb begin
      prod_in = $signed({1'b0, count}) * score;
      diff_in = DIFF_W'(prod_ff) - DIFF_W'(sum);
      key_in  = diff_ff[DIFF_W-1] ? DIFF_W'(-diff_ff) : DIFF_W'(diff_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff <= req.tag;
      prod_ff <= prod_in;
      tag2_ff <= tag1_ff;
      diff_ff <= diff_in;
      tag3_ff <= tag2_ff;
      key_ff  <= key_in;
      pos_ff  <= !diff_ff[DIFF_W-1] && (diff_ff != '0);
      neg_ff  <= diff_ff[DIFF_W-1];
   end

   assign rsp.valid = v3_ff;
   assign rsp.tag   = tag3_ff;
   assign rsp.key   = key_ff;
   assign rsp.pos   = pos_ff;
   assign rsp.neg   = neg_ff;

endmodule

// ===== rtl/signed_rank_statistic.sv =====
// Signed rank statistic: loads a set, ranks items by |C*local - S|, sums chosen ranks.
//
//  channel  dir  handshake          transaction
//  req_     in   valid / stall      one item: local, global, label, last
//  rsp_     out  valid / stall      one result per set: rank sum, target count
//  csr_     in   valid / ready      register index and write data
//
// Loading takes one transaction per cycle into the item RAM while in the load state.
// After the last item each stored item is fetched as a pivot to get its key, and each
// counted target item scans every stored item, one RAM read per cycle into the key unit.
// req_stall is high for the whole ranking.
// A pending result does not block the next set's loading. Reset is synchronous.
module signed_rank_statistic
   import srs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [SCORE_W-1:0] req_local_score,
   input  logic signed [SCORE_W-1:0] req_global_score,
   input  logic [LABEL_W-1:0]        req_label,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [RANK_SUM_W-1:0]     rsp_rank_sum,
   output logic [TCOUNT_W-1:0]       rsp_target_count,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_PIVOT = 3'd1;
   localparam logic [2:0] ST_PWAIT = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic signed [DIR_W-1:0]  dir_ff, dir_in;
   logic [LABEL_W-1:0]       target_ff, target_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]         match_ff, match_in;
   logic [CNT_W-1:0]         item_ff, item_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [CNT_W-1:0]         rank_ff, rank_in;
   logic [IDX_W-1:0]         pivot_ff, pivot_in;
   logic [IDX_W-1:0]         scan_ff, scan_in;
   logic                     issued_ff, issued_in;
   logic [DIFF_W-1:0]        pkey_ff, pkey_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RANK_SUM_W-1:0]    rsp_sum_ff, rsp_sum_in;
   logic [TCOUNT_W-1:0]      rsp_cnt_ff, rsp_cnt_in;

   logic                     accept;
   logic                     wr_en;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic [MEM_W-1:0]         rd_data;
   key_req_type              issue;
   key_tag_type              tag_ff;
   logic                     rd_valid_ff;
   key_req_type              unit_req;
   key_rsp_type              unit_rsp;
   logic                     pivot_last;
   logic                     counted;
   logic                     beats;
   logic                     out_free;
   logic [ACC_W-1:0]         acc_final;
   logic [OUTC_W-1:0]        match_ext;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_LOAD);
   assign csr_ready = 1'b1;
   assign wr_en     = accept && (item_ff < CNT_W'(N_MAX));

   srs_ram #(
      .DEPTH (N_MAX),
      .WIDTH (MEM_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (item_ff[IDX_W-1:0]),
      .wr_data ({req_label, req_local_score}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      issue.valid     = 1'b0;
      issue.tag.last  = 1'b0;
      issue.tag.index = pivot_ff;
      issue.tag.label = '0;
      rd_addr         = pivot_ff;
      if (state_ff == ST_PIVOT) begin
         issue.valid    = 1'b1;
         issue.tag.last = 1'b1;
      end else if (state_ff == ST_SCAN && !issued_ff) begin
         issue.valid     = 1'b1;
         issue.tag.index = scan_ff;
         issue.tag.last  = (CNT_W'(scan_ff) + CNT_W'(1) == item_ff);
         rd_addr         = scan_ff;
      end
   end
   assign rd_en = issue.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue.valid;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= issue.tag;
   end

   always_comb begin
      unit_req.valid     = rd_valid_ff;
      unit_req.tag.last  = tag_ff.last;
      unit_req.tag.index = tag_ff.index;
      unit_req.tag.label = rd_data[MEM_W-1:SCORE_W];
   end

   srs_key_unit u_key (
      .clock (clock),
      .reset (reset),
      .req   (unit_req),
      .score ($signed(rd_data[SCORE_W-1:0])),
      .count (match_ff),
      .sum   (sum_ff),
      .rsp   (unit_rsp)
   );

   assign pivot_last = (CNT_W'(pivot_ff) + CNT_W'(1) == item_ff);
   assign counted    = (unit_rsp.tag.label == target_ff) &&
                       ((dir_ff == DIR_ABOVE && unit_rsp.pos) ||
                        (dir_ff == DIR_BELOW && unit_rsp.neg));
   assign beats      = (unit_rsp.tag.index != pivot_ff) &&
                       ((unit_rsp.key < pkey_ff) ||
                        (unit_rsp.key == pkey_ff && unit_rsp.tag.index < pivot_ff));
   assign acc_final  = acc_ff + ACC_W'(rank_ff) + ACC_W'(beats);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign match_ext  = OUTC_W'(match_ff);

   always_comb begin
      state_in     = state_ff;
      dir_in       = dir_ff;
      target_in    = target_ff;
      sum_in       = sum_ff;
      match_in     = match_ff;
      item_in      = item_ff;
      acc_in       = acc_ff;
      rank_in      = rank_ff;
      pivot_in     = pivot_ff;
      scan_in      = scan_ff;
      issued_in    = issued_ff;
      pkey_in      = pkey_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sum_in   = rsp_sum_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DIRECTION:    dir_in    = $signed(csr_wdata[DIR_W-1:0]);
            CSR_TARGET_LABEL: target_in = csr_wdata[LABEL_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (wr_en) begin
                  item_in = item_ff + CNT_W'(1);
                  if (req_label == target_ff) begin
                     sum_in   = sum_ff + SUM_W'(req_global_score);
                     match_in = match_ff + CNT_W'(1);
                  end
               end
               if (req_last) begin
                  state_in = ST_PIVOT;
                  pivot_in = '0;
                  acc_in   = '0;
               end
            end
         end
         ST_PIVOT: begin
            state_in = ST_PWAIT;
         end
         ST_PWAIT: begin
            if (unit_rsp.valid) begin
               pkey_in = unit_rsp.key;
               if (counted) begin
                  state_in  = ST_SCAN;
                  rank_in   = CNT_W'(1);
                  scan_in   = '0;
                  issued_in = 1'b0;
               end else if (pivot_last) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_PIVOT;
                  pivot_in = pivot_ff + IDX_W'(1);
               end
            end
         end
         ST_SCAN: begin
            if (issue.valid) begin
               if (issue.tag.last) begin
                  issued_in = 1'b1;
               end else begin
                  scan_in = scan_ff + IDX_W'(1);
               end
            end
            if (unit_rsp.valid) begin
               if (unit_rsp.tag.last) begin
                  acc_in = acc_final;
                  if (pivot_last) begin
                     state_in = ST_FIN;
                  end else begin
                     state_in = ST_PIVOT;
                     pivot_in = pivot_ff + IDX_W'(1);
                  end
               end else begin
                  rank_in = rank_ff + CNT_W'(beats);
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff[RANK_SUM_W-1:0];
               rsp_cnt_in   = match_ext[TCOUNT_W-1:0];
               sum_in       = '0;
               match_in     = '0;
               item_in      = '0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         dir_ff       <= DIR_ABOVE;
         target_ff    <= '0;
         sum_ff       <= '0;
         match_ff     <= '0;
         item_ff      <= '0;
         acc_ff       <= '0;
         rank_ff      <= '0;
         pivot_ff     <= '0;
         scan_ff      <= '0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dir_ff       <= dir_in;
         target_ff    <= target_in;
         sum_ff       <= sum_in;
         match_ff     <= match_in;
         item_ff      <= item_in;
         acc_ff       <= acc_in;
         rank_ff      <= rank_in;
         pivot_ff     <= pivot_in;
         scan_ff      <= scan_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pkey_ff    <= pkey_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rank_sum     = rsp_sum_ff;
   assign rsp_target_count = rsp_cnt_ff;

   a_match_le_items: assert property (@(posedge clock) disable iff (reset)
      match_ff <= item_ff)
      else $error("target count exceeds stored item count");

   a_no_key_in_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> !unit_rsp.valid && !rd_valid_ff)
      else $error("key unit busy while loading");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      issue.valid |-> CNT_W'(rd_addr) < item_ff)
      else $error("read beyond stored items");

   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> rank_ff <= item_ff)
      else $error("rank exceeds item count");

   a_fin_to_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && out_free |=> state_ff == ST_LOAD && item_ff == '0 && rsp_valid_ff)
      else $error("set not cleared after result");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for signed_rank_statistic: directed table, random sets, overflow set.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import srs_pkg::*;

   localparam logic signed [DIR_W-1:0] DIR_NONE   = 2'sb00;
   localparam logic signed [DIR_W-1:0] DIR_UNUSED = 2'sb10;
   localparam int QUIET_LIMIT   = 60000;
   localparam int CSR_HOLD_OFF  = 20;
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 45;

   typedef enum int {ROW_ITEM, ROW_DIRECTION, ROW_TARGET} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic signed [SCORE_W-1:0] local_score;
      logic signed [SCORE_W-1:0] global_score;
      logic [LABEL_W-1:0]        label;
      logic                      last;
      logic                      typed;
      logic [RANK_SUM_W-1:0]     rank_sum;
      logic [TCOUNT_W-1:0]       target_count;
   } stim_row_type;

   typedef struct packed {
      logic [RANK_SUM_W-1:0] rank_sum;
      logic [TCOUNT_W-1:0]   target_count;
   } rank_total_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [SCORE_W-1:0] req_local_score = '0;
   logic signed [SCORE_W-1:0] req_global_score = '0;
   logic [LABEL_W-1:0]        req_label = '0;
   logic                      req_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [RANK_SUM_W-1:0]     rsp_rank_sum;
   logic [TCOUNT_W-1:0]       rsp_target_count;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   // predictor state
   logic signed [SCORE_W-1:0] held_score [N_MAX];
   logic [LABEL_W-1:0]        held_label [N_MAX];
   longint                    run_sum = 0;
   int                        run_matches = 0;
   int                        held_count = 0;
   logic signed [DIR_W-1:0]   cur_dir = DIR_ABOVE;
   logic [LABEL_W-1:0]        cur_target = '0;
   rank_total_type            awaited_totals [$];

   int                        mismatches = 0;
   int                        burst_left = 1;
   int                        quiet_cycles = 0;
   logic [15:0]               stall_pattern = '0;
   logic [6:0]                stall_tick = '0;
   rank_total_type            head;

   signed_rank_statistic dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void note_mismatch(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d, actual %0d", what, want, got);
   endfunction

   function automatic void load_and_rank(input logic signed [SCORE_W-1:0] loc, glob,
                                         input logic [LABEL_W-1:0] lab, input logic lst);
      longint c, di, dj, ki, kj;
      int unsigned rank, acc;
      int i, j;
      if (held_count < N_MAX) begin
         held_score[held_count] = loc;
         held_label[held_count] = lab;
         if (lab == cur_target) begin
            run_sum += glob;
            run_matches++;
         end
         held_count++;
      end
      if (lst) begin
         c = run_matches;
         acc = 0;
         for (i = 0; i < held_count; i++) begin
            if (held_label[i] == cur_target) begin
               di = c * held_score[i] - run_sum;
               if ((cur_dir == DIR_ABOVE && di > 0) || (cur_dir == DIR_BELOW && di < 0)) begin
                  ki = (di < 0) ? -di : di;
                  rank = 1;
                  for (j = 0; j < held_count; j++) begin
                     if (j != i) begin
                        dj = c * held_score[j] - run_sum;
                        kj = (dj < 0) ? -dj : dj;
                        if (kj < ki || (kj == ki && j < i))
                           rank++;
                     end
                  end
                  acc += rank;
               end
            end
         end
         awaited_totals.push_back('{acc[RANK_SUM_W-1:0], run_matches[TCOUNT_W-1:0]});
         run_sum = 0;
         run_matches = 0;
         held_count = 0;
      end
   endfunction

   // sender works in bursts; a gap between bursts may drop valid
   task automatic push_item(input logic signed [SCORE_W-1:0] loc, glob,
                            input logic [LABEL_W-1:0] lab, input logic lst);
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_local_score  <= loc;
      req_global_score <= glob;
      req_label        <= lab;
      req_last         <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      load_and_rank(loc, glob, lab, lst);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (awaited_totals.size() != 0) @(posedge clock);
      repeat (CSR_HOLD_OFF) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_DIRECTION)
         cur_dir = data[DIR_W-1:0];
      else
         cur_target = data;
   endtask

   function automatic logic signed [SCORE_W-1:0] rand_score();
      unique case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2, 3: return SCORE_W'($urandom_range(0, 8) - 4);
         4: return SCORE_W'($urandom_range(0, 3) << 16);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [LABEL_W-1:0] rand_label();
      unique case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return cur_target;
         6, 7: return cur_target ^ 8'h01;
         8: return ~cur_target;
         default: return LABEL_W'($urandom());
      endcase
   endfunction

   // receiver stalls on a rotating pattern, reloaded whenever stall_tick wraps to zero
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick == 0) begin
         if ($urandom_range(0, 3) == 0)
            stall_pattern <= '0;
         else
            stall_pattern <= 16'($urandom() & $urandom()) & 16'h7fff;
      end else begin
         stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
      rsp_stall <= stall_pattern[0];
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_totals.size() == 0) begin
            note_mismatch("unexpected transaction, rank_sum", -1, rsp_rank_sum);
         end else begin
            head = awaited_totals.pop_front();
            if (rsp_rank_sum !== head.rank_sum)
               note_mismatch("rank_sum", head.rank_sum, rsp_rank_sum);
            if (rsp_target_count !== head.target_count)
               note_mismatch("target_count", head.target_count, rsp_target_count);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      stim_row_type   plan [$];
      rank_total_type want;
      logic signed [DIR_W-1:0] dir_code;
      int phase, sent, set_len, k, pick;

      // reset values, no target items, extremes with a tie
      plan.push_back('{ROW_ITEM, 32'sd5, 32'sd3, 8'd0, 1'b1, 1'b1, 20'd1, 11'd1});
      plan.push_back('{ROW_ITEM, 32'sd5, 32'sd3, 8'd7, 1'b1, 1'b1, 20'd0, 11'd0});
      plan.push_back('{ROW_ITEM, 32'sh7fffffff, 32'sh80000000, 8'd0, 1'b0, 1'b0, 20'd0, 11'd0});
      plan.push_back('{ROW_ITEM, 32'sh80000000, 32'sh7fffffff, 8'd0, 1'b1, 1'b1, 20'd1, 11'd2});
      plan.push_back('{ROW_DIRECTION, 32'sd0, 32'sd0, {6'h3f, DIR_BELOW}, 1'b0, 1'b0, 20'd0, 11'd0});
      plan.push_back('{ROW_ITEM, 32'sd10, 32'sd0, 8'd0, 1'b0, 1'b0, 20'd0, 11'd0});
      plan.push_back('{ROW_ITEM, -32'sd10, 32'sd0, 8'd0, 1'b0, 1'b0, 20'd0, 11'd0});
      plan.push_back('{ROW_ITEM, 32'sd0, 32'sd0, 8'd1, 1'b1, 1'b0, 20'd0, 11'd0});
      plan.push_back('{ROW_DIRECTION, 32'sd0, 32'sd0, {6'h15, DIR_NONE}, 1'b0, 1'b0, 20'd0, 11'd0});
      plan.push_back('{ROW_ITEM, 32'sd3, 32'sd1, 8'd0, 1'b0, 1'b0, 20'd0, 11'd0});
      plan.push_back('{ROW_ITEM, -32'sd3, 32'sd2, 8'd0, 1'b1, 1'b1, 20'd0, 11'd2});
      plan.push_back('{ROW_DIRECTION, 32'sd0, 32'sd0, {6'h2a, DIR_UNUSED}, 1'b0, 1'b0, 20'd0, 11'd0});
      plan.push_back('{ROW_ITEM, 32'sd3, 32'sd1, 8'd0, 1'b0, 1'b0, 20'd0, 11'd0});
      plan.push_back('{ROW_ITEM, -32'sd3, 32'sd2, 8'd0, 1'b1, 1'b1, 20'd0, 11'd2});
      plan.push_back('{ROW_DIRECTION, 32'sd0, 32'sd0, {6'h00, DIR_ABOVE}, 1'b0, 1'b0, 20'd0, 11'd0});
      // target label moved part way through a set
      plan.push_back('{ROW_TARGET, 32'sd0, 32'sd0, 8'hff, 1'b0, 1'b0, 20'd0, 11'd0});
      plan.push_back('{ROW_ITEM, 32'sd1, 32'sd100, 8'hff, 1'b0, 1'b0, 20'd0, 11'd0});
      plan.push_back('{ROW_TARGET, 32'sd0, 32'sd0, 8'h03, 1'b0, 1'b0, 20'd0, 11'd0});
      plan.push_back('{ROW_ITEM, 32'sd50, 32'sd7, 8'h03, 1'b0, 1'b0, 20'd0, 11'd0});
      plan.push_back('{ROW_ITEM, 32'sd9, -32'sd5, 8'hff, 1'b0, 1'b0, 20'd0, 11'd0});
      plan.push_back('{ROW_ITEM, -32'sd20, 32'sd0, 8'h03, 1'b1, 1'b0, 20'd0, 11'd0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         unique case (plan[r].kind)
            ROW_DIRECTION: write_reg(CSR_DIRECTION, plan[r].label);
            ROW_TARGET: write_reg(CSR_TARGET_LABEL, plan[r].label);
            default: begin
               push_item(plan[r].local_score, plan[r].global_score, plan[r].label, plan[r].last);
               if (plan[r].typed)
                  awaited_totals[$] = '{plan[r].rank_sum, plan[r].target_count};
            end
         endcase
      end

      for (phase = 0; phase < PHASES; phase++) begin
         pick = $urandom_range(0, 9);
         dir_code = (pick < 4) ? DIR_ABOVE : (pick < 8) ? DIR_BELOW :
                    (pick == 8) ? DIR_NONE : DIR_UNUSED;
         write_reg(CSR_DIRECTION, {6'($urandom()), dir_code});
         write_reg(CSR_TARGET_LABEL, 8'($urandom()));
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                   : $urandom_range(1, 12);
            for (k = 0; k < set_len; k++) begin
               push_item(rand_score(), rand_score(), rand_label(), k == set_len - 1);
               sent++;
            end
         end
      end

      // overflow set: few target items so the ranking pass stays short
      write_reg(CSR_DIRECTION, {6'($urandom()), DIR_ABOVE});
      write_reg(CSR_TARGET_LABEL, 8'($urandom()));
      set_len = N_MAX + 6;
      for (k = 0; k < set_len; k++) begin
         push_item(rand_score(), rand_score(),
                   (k == 0 || k == 1 || k == 500 || k == N_MAX - 1 || k == N_MAX ||
                    k == N_MAX + 5) ? cur_target : cur_target + 8'd1,
                   k == set_len - 1);
      end

      req_valid <= 1'b0;
      while (awaited_totals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (awaited_totals.size() != 0) begin
         want = awaited_totals.pop_front();
         note_mismatch("missing transaction, rank_sum", want.rank_sum, -1);
      end
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/srs_pkg.sv
rtl/srs_ram.sv
rtl/srs_key_unit.sv
rtl/signed_rank_statistic.sv
test/tb_top.sv
